// ----- src/cmf_pkg.sv -----
`default_nettype none
package cmf_pkg;

    localparam int CHANNELS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // input commands (s_axis_tuser)
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    // job operations between front and back
    localparam logic [1:0] OP_WFRAME = 2'd0;
    localparam logic [1:0] OP_RFRAME = 2'd1;
    localparam logic [1:0] OP_RDONE  = 2'd2;

    // result kinds (m_axis_tuser)
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // frame type byte
    localparam logic [7:0] TYPE_WRITE = 8'd1;
    localparam logic [7:0] TYPE_READ  = 8'd2;

    localparam logic [7:0] LEN_BIAS = 8'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  code;
        logic [2:0]  len;     // argument bytes, zero for a read frame
        logic [31:0] data;    // write argument or read completion value
        logic        status;
    } t_job;

    function automatic logic [7:0] code_of(input logic [3:0] ch);
        logic [7:0] c;
        case (ch)
            4'd0:    c = 8'h90;
            4'd1:    c = 8'h91;
            4'd2:    c = 8'h92;
            4'd3:    c = 8'h93;
            4'd4:    c = 8'h94;
            4'd5:    c = 8'h96;
            4'd6:    c = 8'h97;
            4'd7:    c = 8'h98;
            4'd8:    c = 8'hA0;
            4'd9:    c = 8'hA1;
            4'd10:   c = 8'hA2;
            4'd11:   c = 8'hA3;
            4'd12:   c = 8'hA5;
            4'd13:   c = 8'hA7;
            4'd14:   c = 8'hB0;
            default: c = 8'hB1;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] len_of(input logic [3:0] ch);
        logic [2:0] l;
        case (ch)
            4'd1, 4'd11, 4'd12, 4'd13: l = 3'd2;
            4'd6, 4'd14:               l = 3'd4;
            default:                   l = 3'd1;
        endcase
        return l;
    endfunction

endpackage
`default_nettype wire

// ----- src/command_frame_link.sv -----
// An accepted item's job passes through the job queue and the back end's output register
// before its first result shows. Results leave at one per cycle while the output is ready:
// a write frame has 5, 6 or 8 bytes, a read frame 4, a read completion is one result.
// Items are taken one per cycle while the job queue (QUEUE_DEPTH jobs) has room; writes
// that match the cache, response bytes before the last and items with no result use no queue slot.
// Reset (synchronous, active low) clears the cache, pending read and queue; check_enable = 1.
`default_nettype none
module command_frame_link #(
    parameter int CHANNELS    = cmf_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = cmf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // channel[3:0], value[35:4], update_cache[36], rx_byte[44:37], zero pad
    input  wire  [47:0] s_axis_tdata,
    // cmd[1:0]
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tx_byte[7:0], read_value[39:8], status[40], zero pad
    output logic [47:0] m_axis_tdata,
    // kind[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic          r_check_en;
    logic          q_full;
    logic          q_valid;
    logic          push;
    logic          pop;
    cmf_pkg::t_job push_job;
    cmf_pkg::t_job head_job;
    logic [7:0]    tx_byte;
    logic [31:0]   read_value;
    logic          status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_check_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_en <= 1'b1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_check_en <= pwdata[0];
        end
    end

    cmf_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_channel  (s_axis_tdata[3:0]),
        .i_value    (s_axis_tdata[35:4]),
        .i_update   (s_axis_tdata[36]),
        .i_rx_byte  (s_axis_tdata[44:37]),
        .i_check_en (r_check_en),
        .i_full     (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    cmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    cmf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_kind       (m_axis_tuser),
        .o_tx_byte    (tx_byte),
        .o_last       (m_axis_tlast),
        .o_read_value (read_value),
        .o_status     (status)
    );

    assign m_axis_tdata = {7'd0, status, read_value, tx_byte};

endmodule
`default_nettype wire

// ----- src/cmf_front.sv -----
`default_nettype none
module cmf_front #(
    parameter int CHANNELS = cmf_pkg::CHANNELS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [1:0]        i_cmd,
    input  wire  [3:0]        i_channel,
    input  wire  [31:0]       i_value,
    input  wire               i_update,
    input  wire  [7:0]        i_rx_byte,
    input  wire               i_check_en,
    input  wire               i_full,
    output logic              o_push,
    output cmf_pkg::t_job     o_job
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [4:0] CH_LIM = 5'(CHANNELS);

    logic [31:0] r_cache [CHANNELS];
    logic        r_pend;
    logic [3:0]  r_pend_ch;
    logic        r_pend_upd;
    logic [2:0]  r_rx_cnt;
    logic [7:0]  r_rx_sum;
    logic [31:0] r_rx_val;

    logic        n_pend;
    logic [3:0]  n_pend_ch;
    logic        n_pend_upd;
    logic [2:0]  n_rx_cnt;
    logic [7:0]  n_rx_sum;
    logic [31:0] n_rx_val;

    logic             accept;
    logic             in_range;
    logic [IDX_W-1:0] cidx;
    logic [IDX_W-1:0] pidx;
    logic [31:0]      cached;
    logic [2:0]       plen;
    logic [1:0]       lane;
    logic             good;
    logic             cw_en;
    logic [IDX_W-1:0] cw_idx;
    logic [31:0]      cw_data;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign in_range = ({1'b0, i_channel} < CH_LIM);
    assign cidx     = i_channel[IDX_W-1:0];
    assign pidx     = r_pend_ch[IDX_W-1:0];
    assign cached   = r_cache[cidx];
    assign plen     = cmf_pkg::len_of(r_pend_ch);
    assign lane     = 2'(r_rx_cnt - 3'd2);
    assign good     = !i_check_en || (i_rx_byte == r_rx_sum);

    always_comb begin
        o_push     = 1'b0;
        o_job      = '0;
        cw_en      = 1'b0;
        cw_idx     = cidx;
        cw_data    = i_value;
        n_pend     = r_pend;
        n_pend_ch  = r_pend_ch;
        n_pend_upd = r_pend_upd;
        n_rx_cnt   = r_rx_cnt;
        n_rx_sum   = r_rx_sum;
        n_rx_val   = r_rx_val;
        if (accept) begin
            case (i_cmd)
                cmf_pkg::CMD_WRITE: begin
                    if (in_range && (i_value != cached)) begin
                        o_push     = 1'b1;
                        o_job.op   = cmf_pkg::OP_WFRAME;
                        o_job.code = cmf_pkg::code_of(i_channel);
                        o_job.len  = cmf_pkg::len_of(i_channel);
                        o_job.data = i_value;
                        cw_en      = 1'b1;
                    end
                end
                cmf_pkg::CMD_READ: begin
                    if (in_range) begin
                        o_push     = 1'b1;
                        o_job.op   = cmf_pkg::OP_RFRAME;
                        o_job.code = cmf_pkg::code_of(i_channel);
                        n_pend     = 1'b1;
                        n_pend_ch  = i_channel;
                        n_pend_upd = i_update;
                        n_rx_cnt   = '0;
                        n_rx_sum   = '0;
                        n_rx_val   = '0;
                    end
                end
                cmf_pkg::CMD_RX: begin
                    if (r_pend) begin
                        if ({1'b0, r_rx_cnt} < ({1'b0, plen} + 4'd2)) begin
                            // reserved bytes only feed the sum; argument bytes fill LSB first
                            if (r_rx_cnt >= 3'd2) begin
                                case (lane)
                                    2'd0:    n_rx_val[7:0]   = i_rx_byte;
                                    2'd1:    n_rx_val[15:8]  = i_rx_byte;
                                    2'd2:    n_rx_val[23:16] = i_rx_byte;
                                    default: n_rx_val[31:24] = i_rx_byte;
                                endcase
                            end
                            n_rx_sum = r_rx_sum + i_rx_byte;
                            n_rx_cnt = r_rx_cnt + 3'd1;
                        end else begin
                            o_push       = 1'b1;
                            o_job.op     = cmf_pkg::OP_RDONE;
                            o_job.data   = good ? r_rx_val : 32'd0;
                            o_job.status = !good;
                            cw_en        = good && r_pend_upd;
                            cw_idx       = pidx;
                            cw_data      = r_rx_val;
                            n_pend       = 1'b0;
                            n_pend_upd   = 1'b0;
                            n_rx_cnt     = '0;
                            n_rx_sum     = '0;
                            n_rx_val     = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_cache[i] <= '0;
            end
            r_pend     <= 1'b0;
            r_pend_ch  <= '0;
            r_pend_upd <= 1'b0;
            r_rx_cnt   <= '0;
            r_rx_sum   <= '0;
            r_rx_val   <= '0;
        end else begin
            if (cw_en) begin
                r_cache[cw_idx] <= cw_data;
            end
            r_pend     <= n_pend;
            r_pend_ch  <= n_pend_ch;
            r_pend_upd <= n_pend_upd;
            r_rx_cnt   <= n_rx_cnt;
            r_rx_sum   <= n_rx_sum;
            r_rx_val   <= n_rx_val;
        end
    end

endmodule
`default_nettype wire

// ----- src/cmf_queue.sv -----
`default_nettype none
module cmf_queue #(
    parameter int DEPTH = cmf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  cmf_pkg::t_job     i_job,
    output logic              o_full,
    output logic              o_valid,
    output cmf_pkg::t_job     o_job,
    input  wire               i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmf_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({i_push && !o_full, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // the front must hold off while the queue is full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job pushed into full queue");

endmodule
`default_nettype wire

// ----- src/cmf_back.sv -----
`default_nettype none
module cmf_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_job_valid,
    input  cmf_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_ready,
    output logic              o_kind,
    output logic [7:0]        o_tx_byte,
    output logic              o_last,
    output logic [31:0]       o_read_value,
    output logic              o_status
);

    logic [2:0]  r_idx;
    logic [7:0]  r_sum;
    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_tx;
    logic        r_last;
    logic [31:0] r_rval;
    logic        r_status;

    logic       load;
    logic       is_done;
    logic [2:0] last_idx;
    logic       at_end;
    logic [1:0] lane_full;
    logic [7:0] data_byte;
    logic [7:0] n_byte;

    assign load      = i_job_valid && (!r_valid || i_ready);
    assign is_done   = (i_job.op == cmf_pkg::OP_RDONE);
    assign last_idx  = is_done ? 3'd0 : (i_job.len + 3'd3);
    assign at_end    = (r_idx == last_idx);
    assign lane_full = 2'(r_idx - 3'd3);
    assign o_pop     = load && at_end;

    always_comb begin
        case (lane_full)
            2'd0:    data_byte = i_job.data[7:0];
            2'd1:    data_byte = i_job.data[15:8];
            2'd2:    data_byte = i_job.data[23:16];
            default: data_byte = i_job.data[31:24];
        endcase
        case (r_idx)
            3'd0:    n_byte = i_job.code;
            3'd1:    n_byte = {5'd0, i_job.len} + cmf_pkg::LEN_BIAS;
            3'd2:    n_byte = (i_job.op == cmf_pkg::OP_RFRAME) ? cmf_pkg::TYPE_READ
                                                               : cmf_pkg::TYPE_WRITE;
            default: n_byte = at_end ? r_sum : data_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_sum   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                if (at_end) begin
                    r_idx <= '0;
                    r_sum <= '0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                    r_sum <= r_sum + n_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (is_done) begin
                r_kind   <= cmf_pkg::KIND_DONE;
                r_tx     <= '0;
                r_last   <= 1'b0;
                r_rval   <= i_job.data;
                r_status <= i_job.status;
            end else begin
                r_kind   <= cmf_pkg::KIND_TX;
                r_tx     <= n_byte;
                r_last   <= at_end;
                r_rval   <= '0;
                r_status <= 1'b0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_tx_byte    = r_tx;
    assign o_last       = r_last;
    assign o_read_value = r_rval;
    assign o_status     = r_status;

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == cmf_pkg::KIND_DONE) |-> (!r_last && r_tx == 8'd0))
        else $error("completion carries frame fields");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == cmf_pkg::KIND_DONE && r_status) |-> (r_rval == 32'd0))
        else $error("failed completion with nonzero value");

    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == cmf_pkg::KIND_TX) |-> (r_rval == 32'd0 && !r_status))
        else $error("transmit byte carries completion fields");

    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop) |=> (r_idx == 3'd0))
        else $error("byte index not rewound after job");

endmodule
`default_nettype wire

// ----- sim/cmf_link_checker.sv -----
`timescale 1ns / 1ps
module cmf_link_checker #(
    parameter logic [2:0] CHECK_EN_ADDR = 3'd0
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [47:0] s_axis_tdata,
    input  wire  [1:0]  s_axis_tuser,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [47:0] m_axis_tdata,
    input  wire         m_axis_tuser,
    input  wire         m_axis_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_completions
);

    // channel 15 in the top byte down to channel 0 in the bottom one
    localparam logic [127:0] CODE_TAB = {
        8'hB1, 8'hB0, 8'hA7, 8'hA5, 8'hA3, 8'hA2, 8'hA1, 8'hA0,
        8'h98, 8'h97, 8'h96, 8'h94, 8'h93, 8'h92, 8'h91, 8'h90
    };
    localparam logic [47:0] ARG_LEN = {
        3'd1, 3'd4, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1
    };

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        frame_last;
        logic [31:0] read_value;
        logic        status;
    } t_link_result;

    logic [31:0]  link_cache [16];
    logic         rd_armed;
    logic [3:0]   rd_chan;
    logic         rd_store;
    int           rx_pos;
    logic [7:0]   rx_sum;
    logic [31:0]  rx_word;
    logic         check_en;
    t_link_result frame_q [$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_results     = 0;
        o_completions = 0;
    end

    function automatic void push_tx(input logic [7:0] b, input logic last);
        t_link_result r;
        r = '0;
        r.kind       = cmf_pkg::KIND_TX;
        r.tx_byte    = b;
        r.frame_last = last;
        frame_q.push_back(r);
    endfunction

    task automatic predict_item(input logic [1:0] cmd, input logic [47:0] d);
        logic [3:0]   ch;
        logic [31:0]  v;
        logic [7:0]   rx;
        logic [7:0]   code;
        logic [7:0]   sum;
        logic [7:0]   b;
        logic         good;
        int           n;
        int           i;
        t_link_result r;
        ch   = d[3:0];
        v    = d[35:4];
        rx   = d[44:37];
        code = CODE_TAB[ch*8 +: 8];
        case (cmd)
            cmf_pkg::CMD_WRITE: begin
                // all 32 bits decide, even when fewer argument bytes go out
                if (v != link_cache[ch]) begin
                    link_cache[ch] = v;
                    n   = int'(ARG_LEN[ch*3 +: 3]);
                    sum = code + (8'(n) + cmf_pkg::LEN_BIAS) + cmf_pkg::TYPE_WRITE;
                    push_tx(code, 1'b0);
                    push_tx(8'(n) + cmf_pkg::LEN_BIAS, 1'b0);
                    push_tx(cmf_pkg::TYPE_WRITE, 1'b0);
                    for (i = 0; i < n; i++) begin
                        b = v[8*i +: 8];
                        sum += b;
                        push_tx(b, 1'b0);
                    end
                    push_tx(sum, 1'b1);
                end
            end
            cmf_pkg::CMD_READ: begin
                push_tx(code, 1'b0);
                push_tx(cmf_pkg::LEN_BIAS, 1'b0);
                push_tx(cmf_pkg::TYPE_READ, 1'b0);
                push_tx(code + cmf_pkg::LEN_BIAS + cmf_pkg::TYPE_READ, 1'b1);
                // a new read drops any reception in progress
                rd_armed = 1'b1;
                rd_chan  = ch;
                rd_store = d[36];
                rx_pos   = 0;
                rx_sum   = '0;
                rx_word  = '0;
            end
            cmf_pkg::CMD_RX: begin
                if (rd_armed) begin
                    n = int'(ARG_LEN[rd_chan*3 +: 3]);
                    if (rx_pos < n + 2) begin
                        if (rx_pos >= 2)
                            rx_word[8*(rx_pos-2) +: 8] = rx;
                        rx_sum += rx;
                        rx_pos++;
                    end else begin
                        good = !check_en || (rx == rx_sum);
                        if (good && rd_store)
                            link_cache[rd_chan] = rx_word;
                        r = '0;
                        r.kind       = cmf_pkg::KIND_DONE;
                        r.read_value = good ? rx_word : 32'd0;
                        r.status     = !good;
                        frame_q.push_back(r);
                        rd_armed = 1'b0;
                        rd_store = 1'b0;
                        rx_pos   = 0;
                        rx_sum   = '0;
                        rx_word  = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_link_result got;
        t_link_result want;
        got.kind       = m_axis_tuser;
        got.tx_byte    = m_axis_tdata[7:0];
        got.frame_last = m_axis_tlast;
        got.read_value = m_axis_tdata[39:8];
        got.status     = m_axis_tdata[40];
        o_results++;
        if (got.kind == cmf_pkg::KIND_DONE)
            o_completions++;
        if (frame_q.size() == 0) begin
            if (o_fail_count < 10)
                $display("%t: unexpected result kind %0d tx %02h last %0d value %08h status %0d",
                         $realtime, got.kind, got.tx_byte, got.frame_last, got.read_value,
                         got.status);
            o_fail_count++;
        end else begin
            want = frame_q.pop_front();
            if (got !== want || m_axis_tdata[47:41] !== 7'd0) begin
                if (o_fail_count < 10) begin
                    $display("%t: result %0d differs", $realtime, o_results);
                    $display("  expected kind %0d tx %02h last %0d value %08h status %0d",
                             want.kind, want.tx_byte, want.frame_last, want.read_value,
                             want.status);
                    $display("  actual   kind %0d tx %02h last %0d value %08h status %0d pad %02h",
                             got.kind, got.tx_byte, got.frame_last, got.read_value,
                             got.status, m_axis_tdata[47:41]);
                end
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (link_cache[i])
                link_cache[i] = '0;
            rd_armed = 1'b0;
            rd_chan  = '0;
            rd_store = 1'b0;
            rx_pos   = 0;
            rx_sum   = '0;
            rx_word  = '0;
            check_en = 1'b1;
            frame_q.delete();
        end else begin
            // results out first: nothing leaves in the cycle its item arrives
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, s_axis_tdata);
            if (psel && penable && pwrite && pready && paddr == CHECK_EN_ADDR)
                check_en = pwdata[0];
        end
        o_pending = frame_q.size();
    end

endmodule

// ----- sim/tb_command_frame_link.sv -----
`timescale 1ns / 1ps
module tb_command_frame_link;

    localparam logic [1:0] CMD_UNUSED        = 2'd3;
    localparam logic [2:0] ADDR_CHECK_ENABLE = 3'd0;
    localparam int         HOLD_CYCLES       = 200;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;

    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [47:0] m_axis_tdata;
    wire         m_axis_tuser;
    wire         m_axis_tlast;
    wire  [31:0] prdata;
    wire         pready;

    int send_idle_pct = 16;
    int recv_idle_pct = 60;
    int hold_len      = 0;
    int items_sent    = 0;
    int fail_count;
    int pending;
    int results_seen;
    int completions_seen;

    command_frame_link dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cmf_link_checker #(
        .CHECK_EN_ADDR (ADDR_CHECK_ENABLE)
    ) link_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results_seen),
        .o_completions (completions_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_len != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(negedge i_clk);
                hold_len <= 0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("command_frame_link: mismatch");
        $finish;
    end

    // called and returns at a falling edge
    task automatic send_item(input logic [1:0] cmd, input logic [3:0] ch,
                             input logic [31:0] v, input logic upd, input logic [7:0] rx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, rx, upd, v, ch};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // two reserved bytes, argument bytes, checksum; optionally a write after the
    // first byte, and optionally a broken checksum
    task automatic send_response(input logic [3:0] ch, input logic [31:0] v,
                                 input bit corrupt, input bit mixed);
        logic [7:0] b;
        logic [7:0] sum;
        int         n;
        int         i;
        n   = int'(cmf_pkg::len_of(ch));
        sum = '0;
        for (i = 0; i < n + 2; i++) begin
            b = (i < 2) ? 8'($urandom_range(255)) : v[8*(i-2) +: 8];
            sum += b;
            send_item(cmf_pkg::CMD_RX, 4'($urandom_range(15)), $urandom(),
                      1'($urandom_range(1)), b);
            if (mixed && i == 0)
                send_item(cmf_pkg::CMD_WRITE, 4'($urandom_range(15)), $urandom(),
                          1'($urandom_range(1)), 8'($urandom_range(255)));
        end
        if (corrupt)
            sum ^= 8'd1 << $urandom_range(7);
        send_item(cmf_pkg::CMD_RX, 4'($urandom_range(15)), $urandom(),
                  1'($urandom_range(1)), sum);
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (12) @(negedge i_clk);
    endtask

    task automatic run_random(input int target);
        logic [3:0]  ch;
        logic [31:0] v;
        int          sel;
        int          i;
        int          cut;
        while (items_sent < target) begin
            ch  = 4'($urandom_range(15));
            sel = $urandom_range(99);
            if (sel < 35) begin
                // small values repeat often, so cache hits come up
                v = ($urandom_range(2) == 0) ? 32'($urandom_range(3)) : $urandom();
                send_item(cmf_pkg::CMD_WRITE, ch, v, 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            end else if (sel < 75) begin
                send_item(cmf_pkg::CMD_READ, ch, $urandom(), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
                send_response(ch, $urandom(), $urandom_range(3) == 0, $urandom_range(6) == 0);
            end else if (sel < 85) begin
                // reception cut short, later bytes or the next read carry on
                send_item(cmf_pkg::CMD_READ, ch, $urandom(), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
                cut = $urandom_range(cmf_pkg::len_of(ch) + 1);
                for (i = 0; i < cut; i++)
                    send_item(cmf_pkg::CMD_RX, 4'($urandom_range(15)), $urandom(),
                              1'($urandom_range(1)), 8'($urandom_range(255)));
            end else if (sel < 95) begin
                send_item(cmf_pkg::CMD_RX, ch, $urandom(), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            end else begin
                send_item(CMD_UNUSED, ch, $urandom(), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        int i;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        reg_write(ADDR_CHECK_ENABLE, 32'd1);

        // writes: equal to cache, byte extremes, upper bits only, long arguments
        send_item(cmf_pkg::CMD_WRITE, 4'd0, 32'h0000_0000, 1'b0, 8'h00);
        send_item(cmf_pkg::CMD_WRITE, 4'd0, 32'h0000_00FF, 1'b1, 8'hFF);
        send_item(cmf_pkg::CMD_WRITE, 4'd6, 32'hFFFF_FFFF, 1'b0, 8'h00);
        send_item(cmf_pkg::CMD_WRITE, 4'd6, 32'hFFFF_FFFF, 1'b0, 8'h00);
        send_item(cmf_pkg::CMD_WRITE, 4'd0, 32'hFFFF_FFFF, 1'b0, 8'h00);
        send_item(cmf_pkg::CMD_WRITE, 4'd14, 32'h8000_0001, 1'b0, 8'h00);
        send_item(CMD_UNUSED, 4'd15, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        // response byte with no read outstanding
        send_item(cmf_pkg::CMD_RX, 4'd0, 32'h0, 1'b0, 8'hAA);
        // good read that refreshes the cache, then a write of the same value
        send_item(cmf_pkg::CMD_READ, 4'd1, 32'h0, 1'b1, 8'h00);
        send_response(4'd1, 32'h0000_5AA5, 1'b0, 1'b0);
        send_item(cmf_pkg::CMD_WRITE, 4'd1, 32'h0000_5AA5, 1'b0, 8'h00);
        // bad checksum
        send_item(cmf_pkg::CMD_READ, 4'd15, 32'h0, 1'b0, 8'h00);
        send_response(4'd15, 32'h0000_0042, 1'b1, 1'b0);
        // second read restarts reception, with a write in the middle
        send_item(cmf_pkg::CMD_READ, 4'd13, 32'h0, 1'b1, 8'h00);
        send_item(cmf_pkg::CMD_RX, 4'd0, 32'h0, 1'b0, 8'h11);
        send_item(cmf_pkg::CMD_READ, 4'd3, 32'h0, 1'b1, 8'h00);
        send_response(4'd3, 32'h0000_00C3, 1'b0, 1'b1);

        run_random(175);
        settle();
        send_idle_pct = 60;
        recv_idle_pct = 16;
        reg_write(ADDR_CHECK_ENABLE, 32'd0);
        run_random(325);
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        reg_write(ADDR_CHECK_ENABLE, 32'd1);

        // long output stall while writes keep coming: the job queue fills
        hold_len <= HOLD_CYCLES;
        for (i = 0; i < 24; i++)
            send_item(cmf_pkg::CMD_WRITE, 4'($urandom_range(15)), $urandom(), 1'b0, 8'h00);
        run_random(450);
        settle();

        $display("%0d items sent over three stall patterns, checksum check on and off,",
                 items_sent);
        $display("a %0d-cycle output hold; %0d results checked, %0d read completions",
                 HOLD_CYCLES, results_seen, completions_seen);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("command_frame_link: match");
        end else begin
            $display("command_frame_link: mismatch");
        end
        $finish;
    end

endmodule
